FILE: rtl/core/tns_pkg.sv
// ----------------------------------------------------------------------------
// tns_pkg
// Shared types and constants for the buzzer tune sequencer.
// ----------------------------------------------------------------------------
package tns_pkg;

  // Tune store geometry
  localparam int unsigned TUNE_DEPTH = 256;
  localparam int unsigned TUNE_AW    = $clog2(TUNE_DEPTH);

  // Reset and fixed values
  localparam logic [7:0] TEMPO_RESET   = 8'd26;
  localparam logic [7:0] PERIOD_SILENT = 8'd255;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_MS_TICK   = 2'd0,
    OP_WRITE     = 2'd1,
    OP_START     = 2'd2,
    OP_TONE_TICK = 2'd3
  } tns_op_t;

  // Input word
  typedef struct packed {
    tns_op_t    op;
    logic [7:0] entry_index;
    logic [7:0] entry_duration;
    logic [7:0] entry_note;
  } tns_in_t;

  // Result word
  typedef struct packed {
    logic        buzzer_level;
    logic        buzzer_enabled;
    logic        playing;
    logic [15:0] ms_count;
  } tns_out_t;

  // Decoded strobes for one processed word
  typedef struct packed {
    logic ms_tick;
    logic wr;
    logic start;
    logic tone_tick;
  } tns_cmd_t;

  // Sequencer status toward the tone generator and result
  typedef struct packed {
    logic       play;
    logic       enable;
    logic [7:0] period;
  } tns_seq_t;

endpackage

FILE: rtl/core/tone_note_sequencer.sv
// ----------------------------------------------------------------------------
// tone_note_sequencer
// Buzzer tune player: tune store, note sequencer and square wave generator.
// ----------------------------------------------------------------------------
// One input word per clock is sustained while out_stall is low. A word is
// registered on acceptance, processed once the result slot is free, and its
// result is then registered in the output stage. The tune store is a 256 x 16
// RAM with registered read; the entry at the play position is prefetched every
// cycle, so a fetch needs no separate step, and no clearing pass runs after
// reset. While a result waits under out_stall, one more word is taken and held.
module tone_note_sequencer
  import tns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  tns_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output tns_out_t   out_data
);

  logic        item_valid_r, item_valid_nxt;
  tns_in_t     item_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] millis_r, millis_nxt;
  logic [7:0]  tempo_r;

  logic        advance;
  logic        fire;
  logic        in_accept;
  tns_cmd_t    cmd;
  tns_seq_t    seq_status;
  logic        pin_level;

  // Handshake: process the held word when the result slot is free
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = item_valid_r && advance;
  assign in_stall  = item_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_accept) begin
      item_valid_nxt = 1'b1;
    end else if (fire) begin
      item_valid_nxt = 1'b0;
    end
    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  // Decode the processed word
  always_comb begin
    cmd = '0;
    if (fire) begin
      case (item_r.op)
        OP_MS_TICK:   cmd.ms_tick   = 1'b1;
        OP_WRITE:     cmd.wr        = 1'b1;
        OP_START:     cmd.start     = 1'b1;
        OP_TONE_TICK: cmd.tone_tick = 1'b1;
        default:      cmd           = '0;
      endcase
    end
  end

  // Bump the millisecond counter
  assign millis_nxt = cmd.ms_tick ? (millis_r + 16'd1) : millis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      millis_r     <= 16'd0;
      tempo_r      <= TEMPO_RESET;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      millis_r     <= millis_nxt;
      if (cfg_we) begin
        tempo_r <= cfg_data;
      end
    end
  end

  // Hold the input word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  tns_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .item   (item_r),
    .tempo  (tempo_r),
    .status (seq_status)
  );

  tns_tone u_tone (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .period    (seq_status.period),
    .pin_level (pin_level)
  );

  // Result comes straight from the updated state registers
  assign out_valid               = out_valid_r;
  assign out_data.buzzer_level   = pin_level;
  assign out_data.buzzer_enabled = seq_status.enable;
  assign out_data.playing        = seq_status.play;
  assign out_data.ms_count       = millis_r;

`ifndef SYNTHESIS
  a_ms_bump: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ms_tick |=> millis_r == 16'($past(millis_r) + 16'd1))
    else $error("millisecond count did not advance");

  a_ms_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(millis_r))
    else $error("millisecond count moved without a word");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && !$past(fire))
    else $error("stalled result dropped or overwritten");
`endif

endmodule

FILE: rtl/core/tns_ram.sv
// ----------------------------------------------------------------------------
// tns_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tns_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read; a read at the written address returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/tns_tone.sv
// ----------------------------------------------------------------------------
// tns_tone
// Square wave generator: 8-bit counter that clears and toggles the pin
// when it meets the tone period.
// ----------------------------------------------------------------------------
module tns_tone
  import tns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tns_cmd_t   cmd,
  input  logic [7:0] period,
  output logic       pin_level
);

  logic [7:0] count_r, count_nxt;
  logic       pin_r, pin_nxt;

  // Advance the counter on a tone-clock tick
  always_comb begin
    count_nxt = count_r;
    pin_nxt   = pin_r;
    if (cmd.tone_tick) begin
      if (count_r == period) begin
        count_nxt = 8'd0;
        pin_nxt   = ~pin_r;
      end else begin
        count_nxt = count_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 8'd0;
      pin_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pin_r   <= pin_nxt;
    end
  end

  assign pin_level = pin_r;

endmodule

FILE: rtl/core/tns_seq.sv
// ----------------------------------------------------------------------------
// tns_seq
// Note sequencer: tune store, read position, note countdown, play flag,
// tone period and output enable.
// ----------------------------------------------------------------------------
module tns_seq
  import tns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tns_cmd_t   cmd,
  input  tns_in_t    item,
  input  logic [7:0] tempo,
  output tns_seq_t   status
);

  logic [7:0]         pos_r, pos_nxt;
  logic [15:0]        remain_r, remain_nxt;
  logic               play_r, play_nxt;
  logic               enable_r, enable_nxt;
  logic [7:0]         period_r, period_nxt;
  logic               byp_r, byp_nxt;
  logic [15:0]        byp_data_r;

  logic               ram_we;
  logic [TUNE_AW-1:0] ram_waddr;
  logic [15:0]        ram_wdata;
  logic [TUNE_AW-1:0] ram_raddr;
  logic [15:0]        ram_rdata;

  logic               pos_in_range;
  logic [8:0]         pos_inc;
  logic [15:0]        pair;
  logic [7:0]         pair_dur;
  logic [7:0]         pair_note;

  // Store a tune entry; out-of-range indexes drop
  assign ram_we    = cmd.wr && ({1'b0, item.entry_index} < 9'(TUNE_DEPTH));
  assign ram_waddr = item.entry_index[TUNE_AW-1:0];
  assign ram_wdata = {item.entry_duration, item.entry_note};

  // Prefetch the entry at the next read position
  assign ram_raddr = pos_nxt[TUNE_AW-1:0];

  tns_ram #(
    .WIDTH (16),
    .DEPTH (TUNE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Forward a write that lands on the prefetched address
  assign byp_nxt = ram_we && (ram_waddr == ram_raddr);

  // Current pair; positions beyond the store read as an end pair
  assign pos_in_range = {1'b0, pos_r} < 9'(TUNE_DEPTH);
  assign pair      = !pos_in_range ? 16'd0 : (byp_r ? byp_data_r : ram_rdata);
  assign pair_dur  = pair[15:8];
  assign pair_note = pair[7:0];
  assign pos_inc   = {1'b0, pos_r} + 9'd1;

  // Count down the note, fetch the next pair at zero, handle start
  always_comb begin
    pos_nxt    = pos_r;
    remain_nxt = remain_r;
    play_nxt   = play_r;
    enable_nxt = enable_r;
    period_nxt = period_r;
    if (cmd.ms_tick && play_r) begin
      if (remain_r != 16'd0) begin
        remain_nxt = remain_r - 16'd1;
      end else begin
        pos_nxt    = (pos_inc >= 9'(TUNE_DEPTH)) ? 8'd0 : pos_inc[7:0];
        remain_nxt = 16'(tempo) * 16'(pair_dur);
        if (pair_dur == 8'd0) begin
          play_nxt = 1'b0;
        end
        if (pair_note != 8'd0) begin
          period_nxt = pair_note;
          enable_nxt = 1'b1;
        end else begin
          period_nxt = PERIOD_SILENT;
          enable_nxt = 1'b0;
        end
      end
    end else if (cmd.start) begin
      pos_nxt  = item.entry_index;
      play_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 8'd0;
      remain_r <= 16'd0;
      play_r   <= 1'b0;
      enable_r <= 1'b0;
      period_r <= PERIOD_SILENT;
      byp_r    <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      remain_r <= remain_nxt;
      play_r   <= play_nxt;
      enable_r <= enable_nxt;
      period_r <= period_nxt;
      byp_r    <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= ram_wdata;
  end

  assign status.play   = play_r;
  assign status.enable = enable_r;
  assign status.period = period_r;

`ifndef SYNTHESIS
  a_start_plays: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> play_r)
    else $error("start did not set play");
`endif

endmodule
